// ----- rtl/cfla_pkg.sv -----
package cfla_pkg;

    // Field widths fixed by the request and result formats
    localparam int REGION_W = 4;
    localparam int BLOCK_W  = 8;
    localparam int OFFSET_W = 20;
    localparam int COUNT_W  = 8;
    localparam int BYTES_W  = 9;

    // Defaults for the top-level parameters
    localparam int DEF_BLOCKS_PER_REGION = 255;
    localparam int DEF_NUM_REGIONS       = 16;

    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 9'd16;

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ALLOC  = 2'd0,
        ST_FREED  = 2'd1,
        ST_OOM    = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_SWEEP,
        S_POP,
        S_LINK,
        S_FREE,
        S_OUT
    } state_t;

    // One entry of the region table
    typedef struct packed {
        logic [BLOCK_W-1:0] head;
        logic [COUNT_W-1:0] count;
    } tab_entry_t;

    // One result item
    typedef struct packed {
        status_t             status;
        logic [REGION_W-1:0] region_index;
        logic [BLOCK_W-1:0]  block_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  free_in_region;
        logic                region_released;
    } res_t;

endpackage

// ----- rtl/cfla_if.sv -----
interface cfla_req_if import cfla_pkg::*;;
    logic                valid;
    logic                ready;
    cmd_t                cmd;
    logic [REGION_W-1:0] free_region;
    logic [BLOCK_W-1:0]  free_block;

    modport source (output valid, output cmd, output free_region, output free_block,
                    input ready);
    modport sink (input valid, input cmd, input free_region, input free_block,
                  output ready);
endinterface

interface cfla_rsp_if import cfla_pkg::*;;
    logic                valid;
    logic                ready;
    status_t             status;
    logic [REGION_W-1:0] region_index;
    logic [BLOCK_W-1:0]  block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  free_in_region;
    logic                region_released;

    modport source (output valid, output status, output region_index, output block_index,
                    output byte_offset, output free_in_region, output region_released,
                    input ready);
    modport sink (input valid, input status, input region_index, input block_index,
                  input byte_offset, input free_in_region, input region_released,
                  output ready);
endinterface

// ----- rtl/chunked_free_list_block_allocator.sv -----
// Fixed-size block allocator over several regions, each with a free list
// threaded through per-block links.
//
// Channels: req carries a command (allocate, or free a named region/block);
// rsp returns one result per request with status, region, block, byte offset,
// the region's free count afterwards and a release flag. cfg_we/cfg_wdata
// write the block size in bytes; write it only while the block is idle.
//
// One request is in work at a time. An out-of-memory allocate goes from
// region selection straight to the result; a free reads the region table,
// then, unless rejected, pushes the block and writes the entry back; an
// allocate from an active region reads the table entry, then the head block's
// link, then writes the entry back; an allocate that activates a region first
// threads all its links (one link write per cycle into the link memory). A new
// request is taken only once the result has passed into the output register.
//
// Reset empties all regions, drops the allocation cache and sets the block
// size to 16 bytes; no memory clearing pass is needed. A stalled rsp holds
// its result in the output register while the next request is worked on;
// that request then waits for the register to free up.
module chunked_free_list_block_allocator import cfla_pkg::*; #(
    parameter int BLOCKS_PER_REGION = DEF_BLOCKS_PER_REGION,
    parameter int NUM_REGIONS       = DEF_NUM_REGIONS,
    localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1,
    localparam int DEPTH = NUM_REGIONS * BLOCKS_PER_REGION,
    localparam int LAW   = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    cfla_req_if.sink           req,
    cfla_rsp_if.source         rsp,
    input  logic               cfg_we,
    input  logic [BYTES_W-1:0] cfg_wdata
);

    logic [BYTES_W-1:0] block_bytes_reg;

    logic               link_we, link_re;
    logic [LAW-1:0]     link_waddr, link_raddr;
    logic [BLOCK_W-1:0] link_wdata, link_rdata;
    logic               tab_we, tab_re;
    logic [RW-1:0]      tab_waddr, tab_raddr;
    tab_entry_t         tab_wdata, tab_rdata;

    logic res_valid, res_ready;
    res_t res;
    res_t out_reg;
    logic out_valid_reg;

    // Block size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BLOCK_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            block_bytes_reg <= cfg_wdata;
        end
    end

    cfla_ctrl #(
        .BLOCKS_PER_REGION (BLOCKS_PER_REGION),
        .NUM_REGIONS       (NUM_REGIONS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .block_bytes (block_bytes_reg),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_re     (link_re),
        .link_raddr  (link_raddr),
        .link_rdata  (link_rdata),
        .tab_we      (tab_we),
        .tab_waddr   (tab_waddr),
        .tab_wdata   (tab_wdata),
        .tab_re      (tab_re),
        .tab_raddr   (tab_raddr),
        .tab_rdata   (tab_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    cfla_ram #(
        .W     (BLOCK_W),
        .DEPTH (DEPTH)
    ) u_link_mem (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    cfla_ram #(
        .W     ($bits(tab_entry_t)),
        .DEPTH (NUM_REGIONS)
    ) u_region_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    // Output register: load a new result when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.region_index    = out_reg.region_index;
    assign rsp.block_index     = out_reg.block_index;
    assign rsp.byte_offset     = out_reg.byte_offset;
    assign rsp.free_in_region  = out_reg.free_in_region;
    assign rsp.region_released = out_reg.region_released;

endmodule

// ----- rtl/cfla_ram.sv -----
module cfla_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/cfla_ctrl.sv -----
module cfla_ctrl import cfla_pkg::*; #(
    parameter int BLOCKS_PER_REGION = DEF_BLOCKS_PER_REGION,
    parameter int NUM_REGIONS       = DEF_NUM_REGIONS,
    localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1,
    localparam int DEPTH = NUM_REGIONS * BLOCKS_PER_REGION,
    localparam int LAW   = $clog2(DEPTH),
    localparam int IW    = $clog2(DEPTH + 256)
) (
    input  logic               clk,
    input  logic               rst_n,
    cfla_req_if.sink           req,
    input  logic [BYTES_W-1:0] block_bytes,
    // link memory
    output logic               link_we,
    output logic [LAW-1:0]     link_waddr,
    output logic [BLOCK_W-1:0] link_wdata,
    output logic               link_re,
    output logic [LAW-1:0]     link_raddr,
    input  logic [BLOCK_W-1:0] link_rdata,
    // region table
    output logic               tab_we,
    output logic [RW-1:0]      tab_waddr,
    output tab_entry_t         tab_wdata,
    output logic               tab_re,
    output logic [RW-1:0]      tab_raddr,
    input  tab_entry_t         tab_rdata,
    // result toward the output register
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res
);

    localparam logic [BLOCK_W-1:0] BPR8 = BLOCK_W'(BLOCKS_PER_REGION);

    state_t state_reg, state_next;

    logic [NUM_REGIONS-1:0] active_reg, active_next;
    logic [NUM_REGIONS-1:0] nz_reg, nz_next;
    logic                   cache_valid_reg, cache_valid_next;
    logic [RW-1:0]          cache_rgn_reg, cache_rgn_next;

    cmd_t                cmd_reg;
    logic [REGION_W-1:0] fr_reg;
    logic [BLOCK_W-1:0]  fb_reg;
    logic [RW-1:0]       rgn_reg, rgn_next;
    logic [BLOCK_W-1:0]  sweep_reg, sweep_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [BLOCK_W-1:0]  blk_reg, blk_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                pop_ok_reg, pop_ok_next;
    logic                rej_reg, rej_next;
    logic                live_reg, live_next;
    res_t                res_reg, res_next;

    logic                accept;
    logic                cache_hit;
    logic                nz_found, ina_found;
    logic [RW-1:0]       nz_idx, ina_idx, pick_rgn, fr_rgn;
    logic                fr_exists, fr_live;
    logic [IW-1:0]       base;
    logic [BLOCK_W-1:0]  new_head;
    logic [COUNT_W-1:0]  new_cnt;
    logic [IW+BYTES_W-1:0] prod;

    assign accept = req.valid && req.ready;

    // Search for the lowest region with free blocks and the lowest inactive one
    always_comb
    begin
        nz_found  = 1'b0;
        ina_found = 1'b0;
        nz_idx    = '0;
        ina_idx   = '0;
        for (int i = NUM_REGIONS - 1; i >= 0; i--)
        begin
            if (nz_reg[i])
            begin
                nz_found = 1'b1;
                nz_idx   = RW'(i);
            end
            if (!active_reg[i])
            begin
                ina_found = 1'b1;
                ina_idx   = RW'(i);
            end
        end
    end

    // Region selection and free checks
    assign cache_hit = cache_valid_reg && nz_reg[cache_rgn_reg];
    assign pick_rgn  = cache_hit ? cache_rgn_reg : nz_idx;
    assign fr_rgn    = RW'(fr_reg);
    assign fr_exists = 32'(fr_reg) < NUM_REGIONS;
    assign fr_live   = fr_exists && active_reg[fr_rgn];
    assign base      = IW'(rgn_reg) * IW'(BLOCKS_PER_REGION);
    assign new_head  = pop_ok_reg ? link_rdata : BPR8;
    assign new_cnt   = tab_rdata.count + 8'd1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    state_next = S_FREE;
                end
                else if (cache_hit || nz_found)
                begin
                    state_next = S_POP;
                end
                else if (ina_found)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SWEEP:
            begin
                if (sweep_reg == BPR8 - 8'd1)
                begin
                    state_next = S_OUT;
                end
            end
            S_POP:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                state_next = S_OUT;
            end
            S_FREE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control per state
    always_comb
    begin
        active_next      = active_reg;
        nz_next          = nz_reg;
        cache_valid_next = cache_valid_reg;
        cache_rgn_next   = cache_rgn_reg;
        rgn_next         = rgn_reg;
        sweep_next       = sweep_reg;
        idx_next         = idx_reg;
        blk_next         = blk_reg;
        cnt_next         = cnt_reg;
        pop_ok_next      = pop_ok_reg;
        rej_next         = rej_reg;
        live_next        = live_reg;
        res_next         = res_reg;
        link_we          = 1'b0;
        link_waddr       = '0;
        link_wdata       = '0;
        link_re          = 1'b0;
        link_raddr       = '0;
        tab_we           = 1'b0;
        tab_waddr        = rgn_reg;
        tab_wdata        = '0;
        tab_re           = 1'b0;
        tab_raddr        = '0;
        unique case (state_reg)
            S_PICK:
            begin
                if (cmd_reg == CMD_FREE)
                begin
                    // Fetch the region entry of the named block
                    rgn_next  = fr_rgn;
                    tab_re    = 1'b1;
                    tab_raddr = fr_rgn;
                    live_next = fr_live;
                    rej_next  = !fr_live || (fb_reg >= BPR8);
                end
                else if (cache_hit || nz_found)
                begin
                    rgn_next  = pick_rgn;
                    tab_re    = 1'b1;
                    tab_raddr = pick_rgn;
                end
                else if (ina_found)
                begin
                    rgn_next   = ina_idx;
                    sweep_next = '0;
                end
                else
                begin
                    // Out of memory: drop the cache, report zeros
                    cache_valid_next = 1'b0;
                    res_next         = '0;
                    res_next.status  = ST_OOM;
                end
            end
            S_SWEEP:
            begin
                // Thread the new region's links i -> i+1
                link_we    = 1'b1;
                link_waddr = LAW'(base + IW'(sweep_reg));
                link_wdata = sweep_reg + 8'd1;
                sweep_next = sweep_reg + 8'd1;
                if (sweep_reg == BPR8 - 8'd1)
                begin
                    // Block 0 goes out at once, head moves to block 1
                    tab_we                   = 1'b1;
                    tab_wdata.head           = 8'd1;
                    tab_wdata.count          = BPR8 - 8'd1;
                    active_next[rgn_reg]     = 1'b1;
                    nz_next[rgn_reg]         = 1'b1;
                    cache_valid_next         = 1'b1;
                    cache_rgn_next           = rgn_reg;
                    idx_next                 = base;
                    res_next                 = '0;
                    res_next.status          = ST_ALLOC;
                    res_next.region_index    = REGION_W'(rgn_reg);
                    res_next.free_in_region  = BPR8 - 8'd1;
                end
            end
            S_POP:
            begin
                // Take the head and fetch its link
                blk_next    = tab_rdata.head;
                cnt_next    = tab_rdata.count - 8'd1;
                pop_ok_next = tab_rdata.head < BPR8;
                idx_next    = base + IW'(tab_rdata.head);
                link_re     = tab_rdata.head < BPR8;
                link_raddr  = LAW'(base + IW'(tab_rdata.head));
            end
            S_LINK:
            begin
                tab_we                  = 1'b1;
                tab_wdata.head          = new_head;
                tab_wdata.count         = cnt_reg;
                nz_next[rgn_reg]        = cnt_reg != '0;
                cache_valid_next        = 1'b1;
                cache_rgn_next          = rgn_reg;
                res_next                = '0;
                res_next.status         = ST_ALLOC;
                res_next.region_index   = REGION_W'(rgn_reg);
                res_next.block_index    = blk_reg;
                res_next.free_in_region = cnt_reg;
            end
            S_FREE:
            begin
                res_next              = '0;
                res_next.region_index = fr_reg;
                res_next.block_index  = fb_reg;
                if (rej_reg || (tab_rdata.count >= BPR8))
                begin
                    res_next.status         = ST_REJECT;
                    res_next.free_in_region = live_reg ? tab_rdata.count : '0;
                end
                else
                begin
                    // Push the block onto the list
                    link_we         = 1'b1;
                    link_waddr      = LAW'(base + IW'(fb_reg));
                    link_wdata      = tab_rdata.head;
                    tab_we          = 1'b1;
                    res_next.status = ST_FREED;
                    if (new_cnt == BPR8)
                    begin
                        // Region wholly free: release it
                        active_next[rgn_reg]     = 1'b0;
                        nz_next[rgn_reg]         = 1'b0;
                        res_next.free_in_region  = BPR8;
                        res_next.region_released = 1'b1;
                        if (cache_valid_reg && (cache_rgn_reg == rgn_reg))
                        begin
                            cache_valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        tab_wdata.head          = fb_reg;
                        tab_wdata.count         = new_cnt;
                        nz_next[rgn_reg]        = 1'b1;
                        res_next.free_in_region = new_cnt;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Scale the block index into a byte offset
    assign prod = (IW + BYTES_W)'(idx_reg) * (IW + BYTES_W)'(block_bytes);

    // Outputs
    assign req.ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_OUT;

    always_comb
    begin
        res = res_reg;
        res.byte_offset = (res_reg.status == ST_ALLOC) ? OFFSET_W'(prod) : '0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_reg      <= '0;
            nz_reg          <= '0;
            cache_valid_reg <= 1'b0;
            cache_rgn_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            active_reg      <= active_next;
            nz_reg          <= nz_next;
            cache_valid_reg <= cache_valid_next;
            cache_rgn_reg   <= cache_rgn_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            fr_reg  <= req.free_region;
            fb_reg  <= req.free_block;
        end
        rgn_reg    <= rgn_next;
        sweep_reg  <= sweep_next;
        idx_reg    <= idx_next;
        blk_reg    <= blk_next;
        cnt_reg    <= cnt_next;
        pop_ok_reg <= pop_ok_next;
        rej_reg    <= rej_next;
        live_reg   <= live_next;
        res_reg    <= res_next;
    end

    // A region with free blocks is always active
    ap_nz_active: assert property (@(posedge clk) disable iff (!rst_n)
        (nz_reg & ~active_reg) == '0)
        else $error("free-block flag set on an inactive region");

    // The allocation cache never names a released region
    ap_cache_active: assert property (@(posedge clk) disable iff (!rst_n)
        cache_valid_reg |-> active_reg[cache_rgn_reg])
        else $error("allocation cache names an inactive region");

    // No new request while a result is offered
    ap_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && res_valid))
        else $error("request taken while a result is pending");

    // An accepted request always starts with region selection
    ap_accept_pick: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PICK)
        else $error("accepted request did not enter region selection");

endmodule
